@@ hw/rtl/fat12_file_read_sequencer_top_macros.svh @@
// Assertion macros for the checker file of the FAT12 read sequencer.
`ifndef FAT12_FILE_READ_SEQUENCER_TOP_MACROS_SVH
`define FAT12_FILE_READ_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define F12RS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define F12RS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/fat12rs_pkg.sv @@
// Types, constants and codes shared by the FAT12 read sequencer files.
package fat12rs_pkg;

   localparam int unsigned FAT_BYTES_DEF    = 8192;
   localparam int unsigned SECTOR_BYTES_DEF = 512;

   localparam int unsigned CNT_W      = 15;
   localparam int unsigned SEC_W      = 24;
   localparam int unsigned POS_W      = 32;
   localparam int unsigned CLU_W      = 24;
   localparam int unsigned SIC_W      = 7;
   localparam int unsigned SPC_W      = 8;
   localparam int unsigned DSS_W      = 16;
   localparam int unsigned LOOK_W     = 17;
   localparam int unsigned OFF_OUT_W  = 9;
   localparam int unsigned LEN_OUT_W  = 10;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0]  MAX_READ     = 15'd16384;
   localparam logic [SPC_W-1:0]  SPC_MAX      = 8'd128;
   localparam logic [11:0]       CHAIN_END    = 12'hFF8;
   localparam logic [15:0]       ENTRY_MASK   = 16'h0FFF;
   localparam logic [CLU_W-1:0]  CLUSTER_BASE = 24'd2;

   localparam logic [1:0] OP_FAT_WRITE = 2'd0;
   localparam logic [1:0] OP_OPEN      = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;
   localparam logic [1:0] OP_SPARE     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPC        = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [12:0] fat_address;
      logic [7:0]  fat_byte;
      logic [11:0] start_cluster;
      logic [23:0] start_sector;
      logic        contiguous;
      logic        dir_flag;
      logic [31:0] file_size;
      logic [14:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [8:0]  buffer_offset;
      logic [9:0]  span_length;
      logic [23:0] fetch_sector;
      logic        fetch_valid;
      logic        chain_end;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_ADD = 2'd1,
      ALU_SUB = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [7:0]  c;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] res;
      logic        borrow;
   } alu_rsp_type;

endpackage

@@ hw/rtl/fat12rs_fat_ram.sv @@
// FAT byte store: one write port, one registered read port.
module fat12rs_fat_ram
   import fat12rs_pkg::*;
#(
   parameter int unsigned DEPTH = FAT_BYTES_DEF,
   parameter int unsigned AW    = $clog2(FAT_BYTES_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fat12rs_alu.sv @@
// Shared arithmetic unit: multiply, three-way add and subtract, result registered.
module fat12rs_alu
   import fat12rs_pkg::*;
(
   input  logic        clock,
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [31:0] prod;
   logic [32:0] diff;
   logic [31:0] res_in;
   logic        borrow_in;
   logic [31:0] res_ff;
   logic        borrow_ff;

   assign prod = req.a[23:0] * req.b[7:0];
   assign diff = {1'b0, req.a} - {1'b0, req.b};

   always_comb begin
      res_in    = '0;
      borrow_in = 1'b0;
      unique case (req.op)
         ALU_MUL: begin
            res_in = {8'd0, prod[23:0]};
         end
         ALU_ADD: begin
            res_in = req.a + req.b + {24'd0, req.c};
         end
         ALU_SUB: begin
            res_in    = diff[31:0];
            borrow_in = diff[32];
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_ff    <= res_in;
      borrow_ff <= borrow_in;
   end

   assign rsp.res    = res_ff;
   assign rsp.borrow = borrow_ff;

endmodule

@@ hw/rtl/fat12_file_read_sequencer_top.sv @@
// FAT12 file read sequencer: cursor, span sequencer and FAT chain walk.
// FAT write and contiguous open: result (if any) strobed the cycle after accept.
// Chain open: result through the multiply, add and emit states, using the shared unit.
// Read: clamp, then spans; a chain-mode sector crossing runs check, multiply, add and emit,
// after the FAT byte pair read at a cluster end; an end mark stops at check.
// Reset clears cursor, mode and data start, sets cluster size to 1; FAT stays undefined until written. No stall.
module fat12_file_read_sequencer_top
   import fat12rs_pkg::*;
#(
   parameter int unsigned FAT_BYTES    = FAT_BYTES_DEF,
   parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_strobe,
   output rsp_type               rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // FAT byte addressing and sector-buffer offset widths follow the parameters.
   localparam int unsigned FAT_AW = $clog2(FAT_BYTES);
   localparam int unsigned OFF_W  = $clog2(SECTOR_BYTES);
   localparam int unsigned TAKE_W = $clog2(SECTOR_BYTES + 1);
   localparam logic [LOOK_W-1:0] FAT_LIMIT  = LOOK_W'(FAT_BYTES);
   localparam logic [TAKE_W-1:0] SECTOR_LEN = TAKE_W'(SECTOR_BYTES);

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_CLAMP = 10'b00_0000_0010,
      S_SPAN  = 10'b00_0000_0100,
      S_RD0   = 10'b00_0000_1000,
      S_RD1   = 10'b00_0001_0000,
      S_NEXT  = 10'b00_0010_0000,
      S_CHK   = 10'b00_0100_0000,
      S_MUL   = 10'b00_1000_0000,
      S_ADD   = 10'b01_0000_0000,
      S_EMIT  = 10'b10_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CLU_W-1:0]     cursor_ff, cursor_in;
   logic [SIC_W-1:0]     sic_ff, sic_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [POS_W-1:0]     size_ff, size_in;
   logic                 contig_ff, contig_in;
   logic                 dir_ff, dir_in;
   logic [DSS_W-1:0]     dss_ff, dss_in;
   logic [SPC_W-1:0]     spc_ff, spc_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [OFF_W-1:0]     span_off_ff, span_off_in;
   logic [TAKE_W-1:0]    span_take_ff, span_take_in;
   logic [LOOK_W-1:0]    look_ff, look_in;
   logic                 lo_ok_ff, lo_ok_in;
   logic                 hi_ok_ff, hi_ok_in;
   logic [7:0]           lo_byte_ff, lo_byte_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic [SPC_W-1:0]     spc_eff;
   logic [CNT_W-1:0]     req_count;
   logic [POS_W-1:0]     left;
   logic [CNT_W-1:0]     clamped;
   logic [OFF_W-1:0]     off;
   logic [TAKE_W-1:0]    room;
   logic [TAKE_W-1:0]    take;
   logic                 full;
   logic [CNT_W-1:0]     count_left;
   logic [POS_W-1:0]     pos_next;
   logic [SPC_W-1:0]     sic_nx;
   logic [LOOK_W-1:0]    look_idx;
   logic [LOOK_W-1:0]    look_nx;
   logic [LOOK_W-1:0]    wr_ext;
   logic [7:0]           hi_byte;
   logic [15:0]          pair;
   logic [15:0]          pair_masked;
   logic [11:0]          entry;

   logic                 ram_wr_en;
   logic [FAT_AW-1:0]    ram_wr_addr;
   logic                 ram_rd_en;
   logic [FAT_AW-1:0]    ram_rd_addr;
   logic [7:0]           ram_rd_data;

   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   function automatic rsp_type make_rsp(input logic [OFF_OUT_W-1:0] o,
                                        input logic [LEN_OUT_W-1:0] l,
                                        input logic [SEC_W-1:0] s,
                                        input logic fv,
                                        input logic ce,
                                        input logic lst);
      rsp_type r;
      r.buffer_offset = o;
      r.span_length   = l;
      r.fetch_sector  = s;
      r.fetch_valid   = fv;
      r.chain_end     = ce;
      r.last          = lst;
      return r;
   endfunction

   fat12rs_fat_ram #(
      .DEPTH (FAT_BYTES),
      .AW    (FAT_AW)
   ) u_fat_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_payload.fat_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fat12rs_alu u_alu (
      .clock (clock),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Cluster size register outside 1..128 is pulled back into range.
   always_comb begin
      if (spc_ff == '0) begin
         spc_eff = SPC_W'(1);
      end else if (spc_ff > SPC_MAX) begin
         spc_eff = SPC_MAX;
      end else begin
         spc_eff = spc_ff;
      end
   end

   // Span arithmetic on the current position.
   assign req_count  = (req_payload.byte_count > MAX_READ) ? MAX_READ : req_payload.byte_count;
   assign left       = alu_rsp.borrow ? '0 : alu_rsp.res;
   assign clamped    = ((!dir_ff || size_ff != '0) && (POS_W'(count_ff) > left))
                       ? CNT_W'(left) : count_ff;
   assign off        = pos_ff[OFF_W-1:0];
   assign room       = SECTOR_LEN - TAKE_W'(off);
   assign take       = (count_ff < CNT_W'(room)) ? TAKE_W'(count_ff) : room;
   assign full       = (take == room);
   assign count_left = count_ff - CNT_W'(take);
   assign pos_next   = pos_ff + POS_W'(take);
   assign sic_nx     = {1'b0, sic_ff} + SPC_W'(1);

   // FAT12 entry n sits at byte n + n/2; odd entries take the upper 12 bits of the pair.
   assign look_idx    = LOOK_W'(cursor_ff[11:0]) + LOOK_W'(cursor_ff[11:1]);
   assign look_nx     = look_ff + LOOK_W'(1);
   assign wr_ext      = LOOK_W'(req_payload.fat_address);
   assign hi_byte     = hi_ok_ff ? ram_rd_data : 8'd0;
   assign pair        = {hi_byte, lo_byte_ff};
   assign pair_masked = pair & ENTRY_MASK;
   assign entry       = cursor_ff[0] ? pair[15:4] : pair_masked[11:0];

   assign ram_wr_en   = accept && (req_payload.operation == OP_FAT_WRITE) && (wr_ext < FAT_LIMIT);
   assign ram_wr_addr = wr_ext[FAT_AW-1:0];
   assign ram_rd_en   = (state_ff == S_RD0) || (state_ff == S_RD1);
   assign ram_rd_addr = (state_ff == S_RD1) ? look_nx[FAT_AW-1:0] : look_ff[FAT_AW-1:0];

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      sic_in        = sic_ff;
      pos_in        = pos_ff;
      size_in       = size_ff;
      contig_in     = contig_ff;
      dir_in        = dir_ff;
      dss_in        = dss_ff;
      spc_in        = spc_ff;
      count_in      = count_ff;
      span_off_in   = span_off_ff;
      span_take_in  = span_take_ff;
      look_in       = look_ff;
      lo_ok_in      = lo_ok_ff;
      hi_ok_in      = hi_ok_ff;
      lo_byte_in    = lo_byte_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      alu_req.op    = ALU_ADD;
      alu_req.a     = '0;
      alu_req.b     = '0;
      alu_req.c     = '0;

      // Register writes land at once; write them only while idle.
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_START: dss_in = csr_write_data[DSS_W-1:0];
            CSR_SPC:        spc_in = csr_write_data[SPC_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_payload.operation)
                  OP_OPEN: begin
                     contig_in    = req_payload.contiguous;
                     dir_in       = req_payload.dir_flag;
                     size_in      = req_payload.file_size;
                     pos_in       = '0;
                     sic_in       = '0;
                     span_off_in  = '0;
                     span_take_in = '0;
                     count_in     = '0;
                     if (req_payload.contiguous) begin
                        cursor_in     = req_payload.start_sector;
                        rsp_strobe_in = 1'b1;
                        rsp_in = make_rsp('0, '0, req_payload.start_sector, 1'b1, 1'b0, 1'b1);
                     end else begin
                        cursor_in = CLU_W'(req_payload.start_cluster);
                        state_in  = S_MUL;
                     end
                  end
                  OP_READ: begin
                     // Bytes left = size - position, borrow means none left.
                     alu_req.op = ALU_SUB;
                     alu_req.a  = size_ff;
                     alu_req.b  = pos_ff;
                     count_in   = req_count;
                     state_in   = S_CLAMP;
                  end
                  default: begin
                     // FAT write goes straight to the RAM; spare code is dropped.
                  end
               endcase
            end
         end
         S_CLAMP: begin
            count_in = clamped;
            if (clamped == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = make_rsp('0, '0, '0, 1'b0, 1'b0, 1'b1);
               state_in      = S_IDLE;
            end else begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            pos_in       = pos_next;
            count_in     = count_left;
            span_off_in  = off;
            span_take_in = take;
            if (!full) begin
               // Span ends inside the sector: nothing to fetch, item done.
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(off[OFF_OUT_W-1:0], take[LEN_OUT_W-1:0], '0,
                                 1'b0, 1'b0, 1'b1);
               state_in = S_IDLE;
            end else if (contig_ff) begin
               cursor_in     = cursor_ff + CLU_W'(1);
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(off[OFF_OUT_W-1:0], take[LEN_OUT_W-1:0],
                                 cursor_ff + CLU_W'(1), 1'b1, 1'b0, count_left == '0);
               state_in = (count_left == '0) ? S_IDLE : S_SPAN;
            end else if (sic_nx >= spc_eff) begin
               // Cluster used up: walk the chain.
               sic_in   = '0;
               look_in  = look_idx;
               state_in = S_RD0;
            end else begin
               sic_in   = sic_nx[SIC_W-1:0];
               state_in = S_CHK;
            end
         end
         S_RD0: begin
            lo_ok_in = (look_ff < FAT_LIMIT);
            state_in = S_RD1;
         end
         S_RD1: begin
            hi_ok_in   = (look_nx < FAT_LIMIT);
            lo_byte_in = lo_ok_ff ? ram_rd_data : 8'd0;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            cursor_in = CLU_W'(entry);
            state_in  = S_CHK;
         end
         S_CHK: begin
            if (cursor_ff >= CLU_W'(CHAIN_END)) begin
               // End-of-chain mark: cut the size here and stop the read.
               size_in       = pos_ff;
               count_in      = '0;
               rsp_strobe_in = 1'b1;
               rsp_in = make_rsp(span_off_ff[OFF_OUT_W-1:0], span_take_ff[LEN_OUT_W-1:0],
                                 '0, 1'b0, 1'b1, 1'b1);
               state_in = S_IDLE;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            alu_req.op = ALU_MUL;
            alu_req.a  = {8'd0, cursor_ff - CLUSTER_BASE};
            alu_req.b  = {24'd0, spc_eff};
            state_in   = S_ADD;
         end
         S_ADD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {16'd0, dss_ff};
            alu_req.b  = alu_rsp.res;
            alu_req.c  = {1'b0, sic_ff};
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in = make_rsp(span_off_ff[OFF_OUT_W-1:0], span_take_ff[LEN_OUT_W-1:0],
                              alu_rsp.res[SEC_W-1:0], 1'b1, 1'b0, count_ff == '0);
            state_in = (count_ff == '0) ? S_IDLE : S_SPAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         sic_ff        <= '0;
         pos_ff        <= '0;
         size_ff       <= '0;
         contig_ff     <= 1'b0;
         dir_ff        <= 1'b0;
         dss_ff        <= '0;
         spc_ff        <= SPC_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         sic_ff        <= sic_in;
         pos_ff        <= pos_in;
         size_ff       <= size_in;
         contig_ff     <= contig_in;
         dir_ff        <= dir_in;
         dss_ff        <= dss_in;
         spc_ff        <= spc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working payload: no reset needed.
   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      span_off_ff  <= span_off_in;
      span_take_ff <= span_take_in;
      look_ff      <= look_in;
      lo_ok_ff     <= lo_ok_in;
      hi_ok_ff     <= hi_ok_in;
      lo_byte_ff   <= lo_byte_in;
      rsp_ff       <= rsp_in;
   end

endmodule

@@ hw/rtl/fat12rs_checker.sv @@
// Port-level checks for the FAT12 read sequencer, bound to the top level.
`include "fat12_file_read_sequencer_top_macros.svh"

module fat12rs_checker
   import fat12rs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input req_type               req_payload,
   input logic                  rsp_strobe,
   input rsp_type               rsp_payload
);

   `F12RS_ASSERT_NEXT(a_silent_ops, clock, reset, start && !busy && (req_payload.operation == OP_FAT_WRITE || req_payload.operation == OP_SPARE), !rsp_strobe && !busy, "FAT write or spare code gave a beat")
   `F12RS_ASSERT_NEXT(a_contig_open, clock, reset, start && !busy && req_payload.operation == OP_OPEN && req_payload.contiguous, rsp_strobe && rsp_payload.last && rsp_payload.fetch_valid && rsp_payload.span_length == '0, "contiguous open beat missing")
   `F12RS_ASSERT_NOW(a_last_idle, clock, reset, rsp_strobe && rsp_payload.last, !busy, "busy after final beat")
   `F12RS_ASSERT_NOW(a_more_busy, clock, reset, rsp_strobe && !rsp_payload.last, busy, "idle before final beat")
   `F12RS_ASSERT_NOW(a_no_fetch_zero, clock, reset, rsp_strobe && !rsp_payload.fetch_valid, rsp_payload.fetch_sector == '0, "sector set without fetch")

endmodule

bind fat12_file_read_sequencer_top fat12rs_checker u_checker (.*);
